>>> rtl/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ffha_pkg.sv
// Shared types, constants and command structs for the first-fit heap allocator.
package ffha_pkg;
    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_NULL    = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [20:0] alloc_size;
        logic [19:0] address;
    } t_in_beat;

    typedef struct packed {
        logic [19:0] payload_offset;
        logic [2:0]  status;
        logic [10:0] used_kb;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, reset scan index
        logic rd;        // issue table read at index
        logic inc;       // index += 1
        logic do_split;  // write used front part at index
        logic ins_rd;    // read entry index-1 for upward shift (index = dest)
        logic ins_wr;    // write shifted entry at index, index -= 1
        logic ins_tail;  // write free remainder at index
        logic do_free;   // mark entry at index free
        logic mrg_rd;    // read entry index+1
        logic mrg_join;  // grow entry at index by next, shift-down start
        logic sh_rd;     // read index during shift-down
        logic sh_wr;     // write the read entry at index-1, index += 1
        logic sh_set;    // index <- merge anchor, count -= 1
        logic finish;    // latch result
        logic [2:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_free;   // read entry is free
        logic fits;      // read entry fits
        logic hit;       // read entry used and offset matches
        logic at_end;    // index >= count
        logic last;      // index + 1 >= count
        logic full;      // count >= max
        logic ins_done;  // index == split index + 1
        logic op;
        logic null_addr;
    } t_sts;
endpackage

>>> rtl/ffha_datapath.sv
// Datapath: segment memory, scan index, counters and result register.
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_req,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_beat o_res
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [20:0] HDR = 21'(HEADER_BYTES);

    typedef struct packed {
        logic [19:0] start;
        logic [20:0] size;
        logic        free;
    } t_seg;

    t_seg        mem [MAX_SEGMENTS];
    t_seg        r_rd, r_hold;
    t_in_beat    r_req;
    logic [CW-1:0] r_idx, r_cnt, r_anchor;
    logic [20:0] r_bytes;
    t_out_beat   r_res;

    // one extra bit so a huge request cannot wrap past the header
    logic [21:0] need;
    assign need = {1'b0, r_req.alloc_size} + 22'(HEADER_BYTES);

    // write port select
    logic        we;
    logic [IW-1:0] wa;
    t_seg        wd;
    always_comb begin
        we = 1'b0;
        wa = r_idx[IW-1:0];
        wd = r_rd;
        if (i_cmd.do_split) begin
            we = 1'b1;
            wd = '{start: r_rd.start, size: r_req.alloc_size, free: 1'b0};
        end else if (i_cmd.ins_wr) begin
            we = 1'b1;
        end else if (i_cmd.ins_tail) begin
            we = 1'b1;
            wd = '{start: r_hold.start + need[19:0], size: r_hold.size - need[20:0],
                   free: 1'b1};
        end else if (i_cmd.do_free) begin
            we = 1'b1;
            wd = '{start: r_rd.start, size: r_rd.size, free: 1'b1};
        end else if (i_cmd.mrg_join) begin
            we = 1'b1;
            wd = '{start: r_hold.start, size: r_hold.size + HDR + r_rd.size,
                   free: 1'b1};
        end else if (i_cmd.sh_wr) begin
            we = 1'b1;
            wa = r_idx[IW-1:0] - IW'(1);
        end
    end

    logic [IW-1:0] ra;
    always_comb begin
        ra = r_idx[IW-1:0];
        if (i_cmd.ins_rd) ra = r_idx[IW-1:0] - IW'(1);
        else if (i_cmd.mrg_rd) ra = r_idx[IW-1:0] + IW'(1);
        else if (i_cmd.sh_rd) ra = r_idx[IW-1:0];
    end

    // memory: entry 0 rewritten during reset, rest undefined until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            mem[0] <= '{start: '0, size: 21'(HEAP_BYTES) - HDR, free: 1'b1};
        end else if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= CW'(1);
            r_bytes <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) r_idx <= '0;
            if (i_cmd.inc) r_idx <= r_idx + CW'(1);
            if (i_cmd.do_split) begin
                r_anchor <= r_idx;
                r_hold   <= r_rd;
                r_idx    <= r_cnt;
                r_cnt    <= r_cnt + CW'(1);
                r_bytes  <= r_bytes + r_req.alloc_size;
            end
            if (i_cmd.ins_wr) r_idx <= r_idx - CW'(1);
            if (i_cmd.do_free) begin
                r_bytes <= r_bytes - r_rd.size;
                r_idx   <= '0;
            end
            if (i_cmd.mrg_rd) r_hold <= r_rd;
            if (i_cmd.mrg_join) begin
                r_anchor <= r_idx;
                r_idx    <= r_idx + CW'(2);
            end
            if (i_cmd.sh_wr) r_idx <= r_idx + CW'(1);
            // count drops once the shift-down has covered the old tail
            if (i_cmd.sh_set) begin
                r_idx <= r_anchor;
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.finish) begin
            r_res.payload_offset <= (i_cmd.status == ST_OK && r_req.operation == OP_ALLOC)
                ? r_hold.start + HDR[19:0] : '0;
            r_res.status  <= i_cmd.status;
            r_res.used_kb <= r_bytes[20:10];
        end
    end

    // status toward controller
    always_comb begin
        o_sts.is_free   = r_rd.free;
        o_sts.fits      = r_rd.free && ({1'b0, r_rd.size} >= need);
        o_sts.hit       = !r_rd.free &&
                          ({1'b0, r_rd.start} + 21'(HEADER_BYTES) == {1'b0, r_req.address});
        o_sts.at_end    = r_idx >= r_cnt;
        o_sts.last      = (r_idx + CW'(1)) >= r_cnt;
        o_sts.full      = r_cnt >= CW'(MAX_SEGMENTS);
        o_sts.ins_done  = r_idx == r_anchor + CW'(1);
        o_sts.op        = r_req.operation;
        o_sts.null_addr = r_req.address == '0;
    end
    assign o_res = r_res;

    `include "first_fit_heap_allocator_assert.svh"
    `FFHA_ASSERT_IMP(a_cnt_pos, i_clk, i_rst_n, 1'b1, r_cnt != '0)
    `FFHA_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_SEGMENTS))
    `FFHA_ASSERT_NXT(a_split_grow, i_clk, i_rst_n, i_cmd.do_split,
        r_cnt == $past(r_cnt) + CW'(1))
endmodule

>>> rtl/ffha_ctrl.sv
// Controller state machine sequencing scan, insert shift, free and merge.
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2,
                           S_INSR = 4'd3, S_INSW = 4'd4, S_TAIL = 4'd5,
                           S_MRD = 4'd6, S_MCHK = 4'd7, S_SRD = 4'd8,
                           S_SWR = 4'd9, S_DONE = 4'd10, S_MRD2 = 4'd11,
                           S_SCHK = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_out_valid;
    logic       r_shift_more;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                o_cmd.load = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (!i_sts.op || !i_sts.null_addr) begin
                    o_cmd.rd = 1'b1;
                    n_state = i_sts.at_end ? S_DONE : S_CHK;
                end else n_state = S_DONE;
                if (i_sts.at_end || (i_sts.op && i_sts.null_addr)) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_sts.op
                        ? (i_sts.null_addr ? ST_NULL : ST_UNKNOWN) : ST_NOFIT;
                end
            end
            S_CHK: begin
                if (!i_sts.op && i_sts.fits) begin
                    if (i_sts.full) begin
                        o_cmd.finish = 1'b1; o_cmd.status = ST_FULL; n_state = S_DONE;
                    end else begin
                        o_cmd.do_split = 1'b1; n_state = S_INSR;
                    end
                end else if (i_sts.op && i_sts.hit) begin
                    o_cmd.do_free = 1'b1; n_state = S_MRD;
                end else begin
                    o_cmd.inc = 1'b1; n_state = S_RD;
                end
            end
            S_INSR: if (i_sts.ins_done) n_state = S_TAIL;
                    else begin o_cmd.ins_rd = 1'b1; n_state = S_INSW; end
            S_INSW: begin o_cmd.ins_wr = 1'b1; n_state = S_INSR; end
            S_TAIL: begin
                o_cmd.ins_tail = 1'b1; o_cmd.finish = 1'b1; o_cmd.status = ST_OK;
                n_state = S_DONE;
            end
            // merge: r_idx is current; read it then the next
            S_MRD: if (i_sts.last) begin
                o_cmd.finish = 1'b1; o_cmd.status = ST_OK; n_state = S_DONE;
            end else begin
                o_cmd.rd = 1'b1; n_state = S_MRD2;
            end
            S_MRD2: begin o_cmd.mrg_rd = 1'b1; n_state = S_MCHK; end
            // join only when both the current and the next entry are free
            S_MCHK: if (r_shift_more && i_sts.is_free) begin
                o_cmd.mrg_join = 1'b1; n_state = S_SRD;
            end else begin
                o_cmd.inc = 1'b1; n_state = S_MRD;
            end
            S_SRD: if (i_sts.at_end) begin
                o_cmd.sh_set = 1'b1; n_state = S_MRD;
            end else begin
                o_cmd.sh_rd = 1'b1; n_state = S_SWR;
            end
            S_SWR: begin o_cmd.sh_wr = 1'b1; n_state = S_SRD; end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // remember free bit of current entry before reading the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_shift_more <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MRD2) r_shift_more <= i_sts.is_free;
            if (r_state == S_MCHK) r_shift_more <= 1'b0;
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    `include "first_fit_heap_allocator_assert.svh"
    `FFHA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `FFHA_ASSERT_NXT(a_fin_valid, i_clk, i_rst_n, o_cmd.finish, r_out_valid)
    `FFHA_ASSERT_IMP(a_one_wr, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.do_split, o_cmd.ins_wr, o_cmd.ins_tail, o_cmd.do_free,
                  o_cmd.mrg_join, o_cmd.sh_wr}))
endmodule

>>> rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator.
// Usage: one request beat in (i_in_valid/o_in_ready, t_in_beat payload), one
// result beat out (o_out_valid/i_out_ready, t_out_beat payload) per request.
// Scans read and check the table one entry at a time, in S_RD and S_CHK.
// Allocate: scan up to the first free entry that fits, split it into a used
// front part, shift the entries above it up and write the free remainder.
// A scan that finds no fit ends with ST_NOFIT. Free of entry i: a scan to find
// it, then a merge walk over the table, and per merge a shift-down of the
// entries above the joined pair. One request is worked at a time; the next one
// is taken in S_IDLE, after S_DONE, at the earliest.
// The result register holds a finished beat while the receiver stalls; the
// next request is taken once that beat is delivered or leaves in the same cycle.
// Reset (synchronous, active low) makes the table one free segment covering
// the heap, count one, used bytes zero; other entries are undefined until written.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);
    t_cmd cmd;
    t_sts sts;

    ffha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    ffha_datapath #(
        .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_req(i_in_data), .i_cmd(cmd), .o_sts(sts),
        .o_res(o_out_data)
    );
endmodule
